>>> rtl/lzlc_pkg.sv
package lzlc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_LINES  = 256;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LINE_W = $clog2(MAX_LINES);

    localparam logic [CNT_W-1:0] NONE_INDEX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_POINTS);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_ZONE_TOP_Y      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOSTLY_OUT_FRAC = 2'd2;

    localparam logic [16:0] FRAC_RESET = 17'd32768;

    typedef struct packed {
        logic [15:0] zone_top_y;
        logic [15:0] center_x;
        logic [16:0] mostly_out_frac;
    } lzlc_cfg_t;

    typedef struct packed {
        logic signed [32:0] prod_x;
        logic signed [32:0] prod_y;
        logic [15:0]        point_y;
        logic               last_point;
    } lzlc_prod_t;

    typedef struct packed {
        logic [CNT_W-1:0]  point_count;
        logic [CNT_W-1:0]  zone_count;
        logic [CNT_W-1:0]  out_count;
        logic [CNT_W-1:0]  lowest_index;
        logic [LINE_W-1:0] line_number;
    } lzlc_tally_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + CNT_W'(1) : c;
    endfunction

endpackage

>>> rtl/lzlc_dot.sv
module lzlc_dot
    import lzlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzlc_cfg_t   cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    input  logic [15:0] normal_x,
    input  logic [15:0] normal_y,
    input  logic        last_point,
    output logic        prod_valid,
    output lzlc_prod_t  prod,
    input  logic        prod_take
);

    logic        s1_valid_reg;
    logic [15:0] s1_px_reg;
    logic [15:0] s1_py_reg;
    logic [15:0] s1_nx_reg;
    logic [15:0] s1_ny_reg;
    logic        s1_last_reg;

    logic       s2_valid_reg;
    lzlc_prod_t s2_reg;
    lzlc_prod_t s2_next;

    logic s1_ready;
    logic s2_ready;

    logic signed [16:0] dx;

    assign s2_ready = !s2_valid_reg || prod_take;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign dx = $signed({1'b0, s1_px_reg}) - $signed({1'b0, cfg.center_x});

    always_comb
    begin
        s2_next.prod_x     = 33'(dx) * 33'($signed(s1_nx_reg));
        s2_next.prod_y     = 33'($signed({1'b0, s1_py_reg})) * 33'($signed(s1_ny_reg));
        s2_next.point_y    = s1_py_reg;
        s2_next.last_point = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_px_reg   <= point_x;
            s1_py_reg   <= point_y;
            s1_nx_reg   <= normal_x;
            s1_ny_reg   <= normal_y;
            s1_last_reg <= last_point;
        end
        if (s1_valid_reg && s2_ready)
            s2_reg <= s2_next;
    end

    assign prod_valid = s2_valid_reg;
    assign prod       = s2_reg;

endmodule

>>> rtl/lzlc_accum.sv
module lzlc_accum
    import lzlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzlc_cfg_t   cfg,
    input  logic        prod_valid,
    input  lzlc_prod_t  prod,
    output logic        prod_take,
    output logic        tally_valid,
    output lzlc_tally_t tally,
    input  logic        verdict_ready
);

    logic [CNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]  zone_count_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [16:0]       lowest_y_reg;
    logic [CNT_W-1:0]  lowest_index_reg;
    logic [LINE_W-1:0] line_counter_reg;

    logic        s3_valid_reg;
    lzlc_tally_t s3_reg;
    lzlc_tally_t s3_next;

    logic              s3_ready;
    logic signed [33:0] dot;
    logic              dot_pos;
    logic              in_zone;
    logic              is_lower;
    logic [16:0]       lowest_y_cur;
    logic [CNT_W-1:0]  point_count_next;
    logic [CNT_W-1:0]  zone_count_next;
    logic [CNT_W-1:0]  out_count_next;
    logic [16:0]       lowest_y_next;
    logic [CNT_W-1:0]  lowest_index_next;
    logic              line_end;

    assign s3_ready  = !s3_valid_reg || verdict_ready;
    assign prod_take = prod_valid && (!prod.last_point || s3_ready);
    assign line_end  = prod_take && prod.last_point;

    assign dot     = {prod.prod_x[32], prod.prod_x} + {prod.prod_y[32], prod.prod_y};
    assign dot_pos = !dot[33] && (dot != '0);
    assign in_zone = prod.point_y < cfg.zone_top_y;

    // lowest y restarts from twice the zone top at the first point of a line
    assign lowest_y_cur = (point_count_reg == '0) ? {cfg.zone_top_y, 1'b0} : lowest_y_reg;
    assign is_lower     = in_zone && ({1'b0, prod.point_y} < lowest_y_cur);

    always_comb
    begin
        point_count_next  = sat_inc(point_count_reg);
        zone_count_next   = in_zone ? sat_inc(zone_count_reg) : zone_count_reg;
        out_count_next    = (in_zone && dot_pos) ? sat_inc(out_count_reg) : out_count_reg;
        lowest_y_next     = is_lower ? {1'b0, prod.point_y} : lowest_y_cur;
        lowest_index_next = is_lower ? point_count_reg : lowest_index_reg;

        s3_next.point_count  = point_count_next;
        s3_next.zone_count   = zone_count_next;
        s3_next.out_count    = out_count_next;
        s3_next.lowest_index = lowest_index_next;
        s3_next.line_number  = line_counter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= '0;
            zone_count_reg   <= '0;
            out_count_reg    <= '0;
            lowest_y_reg     <= '0;
            lowest_index_reg <= NONE_INDEX;
            line_counter_reg <= '0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            if (line_end)
            begin
                point_count_reg  <= '0;
                zone_count_reg   <= '0;
                out_count_reg    <= '0;
                lowest_y_reg     <= {cfg.zone_top_y, 1'b0};
                lowest_index_reg <= NONE_INDEX;
                line_counter_reg <= (line_counter_reg == LINE_LAST) ? '0
                                    : line_counter_reg + LINE_W'(1);
            end
            else if (prod_take)
            begin
                point_count_reg  <= point_count_next;
                zone_count_reg   <= zone_count_next;
                out_count_reg    <= out_count_next;
                lowest_y_reg     <= lowest_y_next;
                lowest_index_reg <= lowest_index_next;
            end
            if (s3_ready)
                s3_valid_reg <= line_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_end)
            s3_reg <= s3_next;
    end

    assign tally_valid = s3_valid_reg;
    assign tally       = s3_reg;

endmodule

>>> rtl/lzlc_verdict.sv
module lzlc_verdict
    import lzlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzlc_cfg_t   cfg,
    input  logic        tally_valid,
    input  lzlc_tally_t tally,
    output logic        verdict_ready,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  line_number,
    output logic        line_found,
    output logic        mostly_out,
    output logic        forward_dir,
    output logic [10:0] zone_point_count
);

    logic        out_valid_reg;
    logic [7:0]  line_number_reg;
    logic        line_found_reg;
    logic        mostly_out_reg;
    logic        forward_dir_reg;
    logic [10:0] zone_count_reg;

    logic [CNT_W+16:0] lhs;
    logic [CNT_W+16:0] rhs;
    logic              found;
    logic              mostly_next;
    logic              fwd_next;

    assign verdict_ready = !out_valid_reg || res_ready;

    // out/zone > frac/65536, cross-multiplied
    assign lhs = {1'b0, tally.out_count, 16'b0};
    assign rhs = (CNT_W+17)'(cfg.mostly_out_frac) * (CNT_W+17)'(tally.zone_count);

    assign found       = tally.zone_count != '0;
    assign mostly_next = found && (lhs > rhs);
    assign fwd_next    = !found || (tally.lowest_index == NONE_INDEX)
                         || !({tally.lowest_index, 1'b0} > {1'b0, tally.point_count});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (verdict_ready)
            out_valid_reg <= tally_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tally_valid && verdict_ready)
        begin
            line_number_reg <= 8'(tally.line_number);
            line_found_reg  <= found;
            mostly_out_reg  <= mostly_next;
            forward_dir_reg <= fwd_next;
            zone_count_reg  <= 11'(tally.zone_count);
        end
    end

    assign res_valid        = out_valid_reg;
    assign line_number      = line_number_reg;
    assign line_found       = line_found_reg;
    assign mostly_out       = mostly_out_reg;
    assign forward_dir      = forward_dir_reg;
    assign zone_point_count = zone_count_reg;

endmodule

>>> rtl/lane_zone_line_classifier.sv
// Lane zone line classifier: takes one line point per cycle unless m_tready back-pressure
// stalls it (tlast on the final point of each line) and returns one result item per line.
// Points with y less than the zone top are counted, counted again when (point - bottom
// center) dot normal is positive, and the first of them with strictly smallest y is
// remembered; the result carries line number, found, mostly-out, forward direction and the
// zone point count. Throughput is one point per cycle when not stalled; the last point of a
// line passes the input, product, tally and output registers. Counters saturate at 1024.
// The user must write configuration only while no line is in flight; it is not enforced.
module lane_zone_line_classifier
    import lzlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x[15:0], point_y[31:16], normal_x[47:32], normal_y[63:48]
    input  logic [63:0]           s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // line_number[7:0], line_found[8], mostly_out[9], forward_dir[10],
    // zone_point_count[21:11], zero[23:22]
    output logic [23:0]           m_tdata
);

    lzlc_cfg_t cfg_reg;

    logic        prod_valid;
    lzlc_prod_t  prod;
    logic        prod_take;
    logic        tally_valid;
    lzlc_tally_t tally;
    logic        verdict_ready;

    logic [7:0]  line_number;
    logic        line_found;
    logic        mostly_out;
    logic        forward_dir;
    logic [10:0] zone_point_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zone_top_y      <= '0;
            cfg_reg.center_x        <= '0;
            cfg_reg.mostly_out_frac <= FRAC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZONE_TOP_Y:      cfg_reg.zone_top_y      <= cfg_data[15:0];
                REG_CENTER_X:        cfg_reg.center_x        <= cfg_data[15:0];
                REG_MOSTLY_OUT_FRAC: cfg_reg.mostly_out_frac <= cfg_data[16:0];
                default:             ;
            endcase
        end
    end

    lzlc_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .point_x    (s_tdata[15:0]),
        .point_y    (s_tdata[31:16]),
        .normal_x   (s_tdata[47:32]),
        .normal_y   (s_tdata[63:48]),
        .last_point (s_tlast),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_take  (prod_take)
    );

    lzlc_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .prod_valid    (prod_valid),
        .prod          (prod),
        .prod_take     (prod_take),
        .tally_valid   (tally_valid),
        .tally         (tally),
        .verdict_ready (verdict_ready)
    );

    lzlc_verdict u_verdict (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .tally_valid      (tally_valid),
        .tally            (tally),
        .verdict_ready    (verdict_ready),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .line_number      (line_number),
        .line_found       (line_found),
        .mostly_out       (mostly_out),
        .forward_dir      (forward_dir),
        .zone_point_count (zone_point_count)
    );

    assign m_tdata = {2'b00, zone_point_count, forward_dir, mostly_out, line_found, line_number};

endmodule
